### rtl/core/bpa_pkg.sv
// Block pool allocator package: field widths, command and status codes,
// and the packed request and result types used by the top level.
// No dependencies.
package bpa_pkg;

    localparam int NUM_BLOCKS_DEF  = 512;
    localparam int BLOCK_BYTES_DEF = 32;

    localparam int SIZE_W = 16;
    localparam int FOFF_W = 16;
    localparam int AOFF_W = 14;
    localparam int PCT_W  = 7;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] size_bytes;
        logic [FOFF_W-1:0] free_offset;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [AOFF_W-1:0] alloc_offset;
        logic [PCT_W-1:0]  usage_percent;
    } t_result;

endpackage

### rtl/core/block_pool_allocator.sv
// Block pool allocator top level: command FSM, table scan and usage math.
// Depends on bpa_pkg and bpa_table.
//
// Usage:
//   Drive a request on i_cmd and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been produced. The result appears on o_result for exactly
//   one cycle with o_valid high; the receiver cannot hold it off, so capture
//   it in that cycle. Next request may be issued in that same cycle.
// Scan:
//   allocate: the scan reads one table entry per cycle from the top block
//     down through the single RAM read port; a scan that finds no window
//     ends with no-space status.
//   free: reads the head entry, then clears the entries of its run upward.
//   zero-size, oversize or out-of-range requests finish without a scan.
// Reset:
//   i_rst_n low clears control state. After reset the table RAM is swept to
//   zero, one entry per cycle, with busy high; no request is taken during
//   the sweep.
// Usage percent is used_blocks * 100 / NUM_BLOCKS, formed by a reciprocal
// multiply registered in the cycle after the used-block count.
module block_pool_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // byte count -> block count by reciprocal multiply, exact for 17-bit inputs
    localparam int X_W    = SIZE_W + 1;
    localparam int DIV_S  = 26;
    localparam int RCP_W  = DIV_S - 1;
    localparam int PROD_W = X_W + RCP_W;
    localparam int Q_W    = PROD_W - DIV_S;
    localparam logic [63:0] DIV_RCP64 =
        ((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [RCP_W-1:0] DIV_RCP = DIV_RCP64[RCP_W-1:0];

    // used * 100 / NUM_BLOCKS by reciprocal multiply
    localparam int PCT_S  = 26;
    localparam int PCT_RW = 30;
    localparam int PCT_PW = CNT_W + PCT_RW;
    localparam logic [63:0] PCT_RCP64 =
        ((64'd100 << PCT_S) + 64'(NUM_BLOCKS) - 64'd1) / 64'(NUM_BLOCKS);
    localparam logic [PCT_RW-1:0] PCT_RCP = PCT_RCP64[PCT_RW-1:0];

    localparam logic [31:0]      POOL_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [X_W-1:0]   BB_M1      = X_W'(BLOCK_BYTES - 1);
    localparam int               OFFS_W     = IDX_W + 10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DECODE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_HEAD,
        ST_FREE_WAIT,
        ST_FREE_CLR,
        ST_SETTLE,
        ST_DONE
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_need;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  r_used;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_chk_addr;
    logic [IDX_W-1:0]  r_base;
    logic              r_more;
    logic              r_chk_vld;
    t_status           r_status;
    logic [PCT_PW-1:0] r_pct_prod;
    t_result           r_result;
    logic              r_valid;

    logic [X_W-1:0]    mul_x;
    logic [Q_W-1:0]    quot;
    logic [CNT_W-1:0]  rdata;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [CNT_W-1:0]  n_run;
    logic [OFFS_W-1:0] off_full;

    bpa_table #(
        .DEPTH  (NUM_BLOCKS),
        .DATA_W (CNT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // Round size up to blocks for allocate; plain offset for free.
    assign mul_x = (r_cmd.command == CMD_FREE) ? X_W'(r_cmd.free_offset)
                                               : X_W'(r_cmd.size_bytes) + BB_M1;
    assign quot     = r_prod[PROD_W-1:DIV_S];
    assign n_run    = r_run + CNT_W'(1);
    assign off_full = OFFS_W'(r_base) * OFFS_W'(BLOCK_BYTES);

    // Table write port: sweep after reset, mark a window, or clear on free.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = r_need;
            end
            ST_FREE_CLR: begin
                if (r_chk_vld && rdata != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_used    <= '0;
            r_valid   <= 1'b0;
            r_more    <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_valid    <= 1'b0;
            r_pct_prod <= PCT_PW'(r_used) * PCT_PW'(PCT_RCP);
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == LAST_IDX) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(mul_x) * PROD_W'(DIV_RCP);
                    r_state <= ST_DECODE;
                end
                ST_DECODE: begin
                    if (r_cmd.command == CMD_FREE) begin
                        if (32'(r_cmd.free_offset) >= POOL_BYTES) begin
                            r_status <= STAT_RANGE;
                            r_state  <= ST_SETTLE;
                        end else begin
                            r_addr  <= quot[IDX_W-1:0];
                            r_state <= ST_FREE_HEAD;
                        end
                    end else if (r_cmd.size_bytes == '0 ||
                                 32'(quot) > 32'(NUM_BLOCKS)) begin
                        r_status <= STAT_NOSPACE;
                        r_state  <= ST_SETTLE;
                    end else begin
                        r_need    <= CNT_W'(quot);
                        r_addr    <= LAST_IDX;
                        r_more    <= 1'b1;
                        r_chk_vld <= 1'b0;
                        r_run     <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Issue one read per cycle, top block downward.
                    if (r_more) begin
                        r_chk_vld  <= 1'b1;
                        r_chk_addr <= r_addr;
                        r_addr     <= r_addr - IDX_W'(1);
                        if (r_addr == '0) begin
                            r_more <= 1'b0;
                        end
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    // Check the entry read last cycle; a hit overrides the issue.
                    if (r_chk_vld) begin
                        if (rdata == '0) begin
                            r_run <= n_run;
                        end else begin
                            r_run <= '0;
                        end
                        if (rdata == '0 && n_run == r_need) begin
                            r_base  <= r_chk_addr;
                            r_addr  <= r_chk_addr;
                            r_left  <= r_need;
                            r_state <= ST_MARK;
                        end else if (r_chk_addr == '0) begin
                            r_status <= STAT_NOSPACE;
                            r_state  <= ST_SETTLE;
                        end
                    end
                end
                ST_MARK: begin
                    r_addr <= r_addr + IDX_W'(1);
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_used   <= r_used + r_need;
                        r_status <= STAT_OK;
                        r_state  <= ST_SETTLE;
                    end
                end
                ST_FREE_HEAD: begin
                    r_state <= ST_FREE_WAIT;
                end
                ST_FREE_WAIT: begin
                    r_left    <= rdata;
                    r_chk_vld <= 1'b0;
                    r_more    <= 1'b1;
                    if (rdata == '0) begin
                        r_status <= STAT_OK;
                        r_state  <= ST_SETTLE;
                    end else begin
                        r_state <= ST_FREE_CLR;
                    end
                end
                ST_FREE_CLR: begin
                    // Clear the entry read last cycle, read the next one up.
                    if (r_chk_vld && rdata != '0) begin
                        r_used <= r_used - CNT_W'(1);
                    end
                    if (r_more) begin
                        r_chk_vld  <= 1'b1;
                        r_chk_addr <= r_addr;
                        r_addr     <= r_addr + IDX_W'(1);
                        r_left     <= r_left - CNT_W'(1);
                        r_more     <= (r_left != CNT_W'(1)) && (r_addr != LAST_IDX);
                    end else begin
                        r_chk_vld <= 1'b0;
                        if (!r_chk_vld) begin
                            r_status <= STAT_OK;
                            r_state  <= ST_SETTLE;
                        end
                    end
                end
                ST_SETTLE: begin
                    // Let the usage product catch up with the final count.
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_result.status <= r_status;
                    r_result.alloc_offset <=
                        (r_cmd.command == CMD_ALLOC && r_status == STAT_OK)
                            ? off_full[AOFF_W-1:0] : '0;
                    r_result.usage_percent <= r_pct_prod[PCT_S +: PCT_W];
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_DONE))
        else $error("result strobe without a finished command");

    a_start_launches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_MUL))
        else $error("accepted command did not launch");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(NUM_BLOCKS))
        else $error("used block count exceeds pool");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == ST_FREE_CLR) |-> (mem_waddr != r_addr))
        else $error("free clear writes the entry being read");
`endif

endmodule

### rtl/core/bpa_table.sv
// Block table RAM: one write port, one read port, registered read data.
// Depends on bpa_pkg for default sizes.
module bpa_table
    import bpa_pkg::*;
#(
    parameter int DEPTH  = NUM_BLOCKS_DEF,
    parameter int DATA_W = $clog2(NUM_BLOCKS_DEF + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
